// ----- rtl/core/tpp_pkg.sv -----
// Shared constants for the track position predictor.
// Used by every module of the block but tpp_queue; no dependencies.
package tpp_pkg;

  localparam int IN_COORD_W = 12;   // width of pos_x / pos_y on the stream
  localparam int OUT_W      = 14;   // width of predicted_x / predicted_y
  localparam int HELD_W     = 3;    // width of positions_held
  localparam int HIST_DEPTH = 5;    // positions kept per track
  localparam int STEP_CNT   = HIST_DEPTH - 1;

  localparam int S_TDATA_W  = 24;   // pos_x, pos_y
  localparam int M_TDATA_W  = 32;   // predicted_x, predicted_y, positions_held, pad

  localparam int OUT_MIN    = -8192;
  localparam int OUT_MAX    = 8191;

  localparam logic [HELD_W-1:0] HELD_ONE = 3'd1;
  localparam logic [HELD_W-1:0] HELD_MAX = 3'd5;

endpackage

// ----- rtl/core/tpp_front.sv -----
// Front end: accepts position words, keeps the track history and position count,
// and pushes the last steps with the newest position into the work queue.
// Depends on tpp_pkg.
module tpp_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_valid,
  output logic                             s_ready,
  input  logic                             start_track,
  input  logic [tpp_pkg::IN_COORD_W-1:0]   pos_x,
  input  logic [tpp_pkg::IN_COORD_W-1:0]   pos_y,
  output logic                             q_valid,
  input  logic                             q_ready,
  output logic [2*COORD_BITS+tpp_pkg::HELD_W+2*tpp_pkg::STEP_CNT*(COORD_BITS+1)-1:0] q_data
);
  import tpp_pkg::*;

  localparam int C       = COORD_BITS;
  localparam int D_W     = C + 1;
  localparam int IN_BITS = (C < IN_COORD_W) ? C : IN_COORD_W;

  // only four older positions are needed: the fifth-oldest drops out on the shift
  logic [C-1:0]      hist_x [STEP_CNT];
  logic [C-1:0]      hist_y [STEP_CNT];
  logic [HELD_W-1:0] held;
  logic [HELD_W-1:0] held_next;

  logic [C-1:0]          nx [HIST_DEPTH];
  logic [C-1:0]          ny [HIST_DEPTH];
  logic signed [D_W-1:0] dx [STEP_CNT];
  logic signed [D_W-1:0] dy [STEP_CNT];
  logic                  accept;

  assign s_ready = q_ready;
  assign q_valid = s_valid;
  assign accept  = s_valid & q_ready;

  always_comb begin
    nx[0] = C'(pos_x[IN_BITS-1:0]);
    ny[0] = C'(pos_y[IN_BITS-1:0]);
    for (int i = 1; i < HIST_DEPTH; i++) begin
      nx[i] = hist_x[i-1];
      ny[i] = hist_y[i-1];
    end
    for (int i = 0; i < STEP_CNT; i++) begin
      dx[i] = $signed({1'b0, nx[i]}) - $signed({1'b0, nx[i+1]});
      dy[i] = $signed({1'b0, ny[i]}) - $signed({1'b0, ny[i+1]});
    end
    if (start_track) begin
      held_next = HELD_ONE;
    end else if (held < HELD_MAX) begin
      held_next = held + HELD_ONE;
    end else begin
      held_next = HELD_MAX;
    end
  end

  // word layout, low to high: h0x, h0y, held, dx[0..3], dy[0..3]
  always_comb begin
    q_data = '0;
    q_data[C-1:0]           = nx[0];
    q_data[2*C-1:C]         = ny[0];
    q_data[2*C +: HELD_W]   = held_next;
    for (int i = 0; i < STEP_CNT; i++) begin
      q_data[2*C + HELD_W + i*D_W +: D_W]              = dx[i];
      q_data[2*C + HELD_W + (STEP_CNT+i)*D_W +: D_W]   = dy[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < STEP_CNT; i++) begin
        hist_x[i] <= nx[i];
        hist_y[i] <= ny[i];
      end
    end
  end

endmodule

// ----- rtl/core/tpp_queue.sv -----
// Two-entry queue between the front end and the arithmetic back end.
// Depends on nothing but its width parameter.
module tpp_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule

// ----- rtl/core/tpp_back.sv -----
// Back end: four-stage pipeline that forms the weighted step sum, rounds the
// average by a reciprocal multiply, adds the last position and saturates.
// Depends on tpp_pkg.
module tpp_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  logic [2*COORD_BITS+tpp_pkg::HELD_W+2*tpp_pkg::STEP_CNT*(COORD_BITS+1)-1:0] q_data,
  output logic                         o_valid,
  input  logic                         o_ready,
  output logic [tpp_pkg::OUT_W-1:0]    predicted_x,
  output logic [tpp_pkg::OUT_W-1:0]    predicted_y,
  output logic [tpp_pkg::HELD_W-1:0]   positions_held
);
  import tpp_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int D_W   = C + 1;
  localparam int SUM_W = C + 5;
  localparam int MAG_W = C + 4;
  localparam int N_W   = C + 5;
  localparam int X_W   = C + 4;
  localparam int K     = X_W + 3;
  localparam int M_W   = K;
  localparam int P_W   = X_W + M_W;
  localparam int RES_W = C + 6;

  // floor(x / D) == (x * M) >> K for every x below 2**X_W
  localparam logic [M_W-1:0] MUL3 = M_W'((64'd1 << K) / 3 + 64'd1);
  localparam logic [M_W-1:0] MUL5 = M_W'((64'd1 << K) / 5 + 64'd1);
  localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(OUT_MIN);
  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(OUT_MAX);

  logic adv1, adv2, adv3, adv4;

  // stage 1: weighted sum
  logic                    v1;
  logic signed [SUM_W-1:0] s1_sum [2];
  logic [C-1:0]            s1_h0  [2];
  logic [HELD_W-1:0]       s1_held;

  // stage 2: magnitude, rounding offset, pre-shift
  logic                    v2;
  logic [X_W-1:0]          s2_x   [2];
  logic [MAG_W-1:0]        s2_mag [2];
  logic                    s2_neg [2];
  logic [C-1:0]            s2_h0  [2];
  logic                    s2_sel5;
  logic                    s2_bypass;
  logic [HELD_W-1:0]       s2_held;

  // stage 3: reciprocal product
  logic                    v3;
  logic [P_W-1:0]          s3_prod [2];
  logic [MAG_W-1:0]        s3_mag  [2];
  logic                    s3_neg  [2];
  logic [C-1:0]            s3_h0   [2];
  logic                    s3_bypass;
  logic [HELD_W-1:0]       s3_held;

  // stage 4: output register
  logic                    v4;
  logic [OUT_W-1:0]        s4_pred [2];
  logic [HELD_W-1:0]       s4_held;

  assign adv4    = ~v4 | o_ready;
  assign adv3    = ~v3 | adv4;
  assign adv2    = ~v2 | adv3;
  assign adv1    = ~v1 | adv2;
  assign q_ready = adv1;

  assign o_valid        = v4;
  assign predicted_x    = s4_pred[0];
  assign predicted_y    = s4_pred[1];
  assign positions_held = s4_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= q_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // ---- stage 1 ----
  logic [HELD_W-1:0]       in_held;
  logic [HELD_W-1:0]       in_steps;
  logic [HELD_W-1:0]       wt;
  logic signed [D_W-1:0]   dstep;
  logic signed [SUM_W-1:0] de;
  logic signed [SUM_W-1:0] acc [2];

  always_comb begin
    in_held  = q_data[2*C +: HELD_W];
    in_steps = in_held - HELD_ONE;
    wt       = '0;
    dstep    = '0;
    de       = '0;
    for (int a = 0; a < 2; a++) begin
      acc[a] = '0;
      for (int i = 0; i < STEP_CNT; i++) begin
        dstep = q_data[2*C + HELD_W + (a*STEP_CNT+i)*D_W +: D_W];
        de    = SUM_W'(dstep);
        // newest step weighs most; steps past the held count weigh zero
        wt    = (in_steps > HELD_W'(i)) ? in_steps - HELD_W'(i) : '0;
        case (wt)
          3'd1:    acc[a] = acc[a] + de;
          3'd2:    acc[a] = acc[a] + (de <<< 1);
          3'd3:    acc[a] = acc[a] + de + (de <<< 1);
          3'd4:    acc[a] = acc[a] + (de <<< 2);
          default: acc[a] = acc[a];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int a = 0; a < 2; a++) begin
        s1_sum[a] <= acc[a];
        s1_h0[a]  <= q_data[a*C +: C];
      end
      s1_held <= in_held;
    end
  end

  // ---- stage 2 ----
  logic [HELD_W-1:0] st2;
  logic [3:0]        den;
  logic              neg2 [2];
  logic [MAG_W-1:0]  mag2 [2];
  logic [N_W-1:0]    num2 [2];
  logic [X_W-1:0]    x2   [2];

  always_comb begin
    st2 = s1_held - HELD_ONE;
    case (st2)
      3'd2:    den = 4'd3;
      3'd3:    den = 4'd6;
      default: den = 4'd10;
    endcase
    for (int a = 0; a < 2; a++) begin
      neg2[a] = s1_sum[a][SUM_W-1];
      mag2[a] = neg2[a] ? MAG_W'(-s1_sum[a]) : MAG_W'(s1_sum[a]);
      num2[a] = {mag2[a], 1'b0} + N_W'(den);
      // n/6 = (n>>1)/3, n/12 = (n>>2)/3, n/20 = (n>>2)/5
      x2[a]   = (st2 == 3'd2) ? X_W'(num2[a] >> 1) : X_W'(num2[a] >> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      for (int a = 0; a < 2; a++) begin
        s2_x[a]   <= x2[a];
        s2_mag[a] <= mag2[a];
        s2_neg[a] <= neg2[a];
        s2_h0[a]  <= s1_h0[a];
      end
      s2_sel5   <= (st2 == 3'd4);
      s2_bypass <= (st2 < 3'd2);
      s2_held   <= s1_held;
    end
  end

  // ---- stage 3 ----
  logic [M_W-1:0] mconst;

  assign mconst = s2_sel5 ? MUL5 : MUL3;

  always_ff @(posedge clk) begin
    if (adv3) begin
      for (int a = 0; a < 2; a++) begin
        s3_prod[a] <= s2_x[a] * mconst;
        s3_mag[a]  <= s2_mag[a];
        s3_neg[a]  <= s2_neg[a];
        s3_h0[a]   <= s2_h0[a];
      end
      s3_bypass <= s2_bypass;
      s3_held   <= s2_held;
    end
  end

  // ---- stage 4 ----
  logic [MAG_W-1:0]        q4   [2];
  logic signed [RES_W-1:0] hx4  [2];
  logic signed [RES_W-1:0] qx4  [2];
  logic signed [RES_W-1:0] r4   [2];
  logic [OUT_W-1:0]        sat4 [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      // zero or one step: divisor is one, quotient is the magnitude
      q4[a]  = s3_bypass ? s3_mag[a] : MAG_W'(s3_prod[a] >> K);
      hx4[a] = RES_W'(s3_h0[a]);
      qx4[a] = RES_W'(q4[a]);
      r4[a]  = s3_neg[a] ? hx4[a] - qx4[a] : hx4[a] + qx4[a];
      if (r4[a] < RES_MIN) begin
        sat4[a] = OUT_W'(RES_MIN);
      end else if (r4[a] > RES_MAX) begin
        sat4[a] = OUT_W'(RES_MAX);
      end else begin
        sat4[a] = OUT_W'(r4[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      for (int a = 0; a < 2; a++) begin
        s4_pred[a] <= sat4[a];
      end
      s4_held <= s3_held;
    end
  end

endmodule

// ----- rtl/core/track_position_predictor.sv -----
// Top level of the track position predictor: front end, work queue, back end.
// Depends on tpp_pkg, tpp_front, tpp_queue and tpp_back.
//
// Usage
//   Input stream (s_*): one word per frame with the tracked object's centre.
//     s_tuser set starts a new track with this position.
//   Output stream (m_*): one word per input word, in order, with the
//     predicted next centre and the number of positions it was based on.
//   Path: a word accepted on the input is stored in the queue, then passes
//     the back-end registers (weighted sum, rounding set-up, reciprocal multiply,
//     add and saturate) and shows on m_tvalid; m_tready low holds it there.
//   Throughput: one word per cycle while m_tready is high; the history update in
//     the front end keeps pace with every word and the back end is fully pipelined.
//   Stall: when m_tready is low the back pipeline holds its words, the
//     two-entry queue fills, and s_tready drops only once the queue is full.
//   Reset: rst (synchronous) empties the queue and pipeline and clears the
//     position count, so the first word after reset always starts a track.
module track_position_predictor #(
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tpp_pkg::S_TDATA_W-1:0]  s_tdata,   // pos_x[11:0], pos_y[23:12]
  input  logic                           s_tuser,   // start_track
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tpp_pkg::M_TDATA_W-1:0]  m_tdata    // predicted_x[13:0], predicted_y[27:14],
                                                    // positions_held[30:28], zero[31]
);
  import tpp_pkg::*;

  localparam int ENTRY_W = 2*COORD_BITS + HELD_W + 2*STEP_CNT*(COORD_BITS+1);

  logic               fq_valid, fq_ready;
  logic [ENTRY_W-1:0] fq_data;
  logic               qb_valid, qb_ready;
  logic [ENTRY_W-1:0] qb_data;
  logic [OUT_W-1:0]   predicted_x;
  logic [OUT_W-1:0]   predicted_y;
  logic [HELD_W-1:0]  positions_held;

  tpp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_tvalid),
    .s_ready     (s_tready),
    .start_track (s_tuser),
    .pos_x       (s_tdata[IN_COORD_W-1:0]),
    .pos_y       (s_tdata[2*IN_COORD_W-1:IN_COORD_W]),
    .q_valid     (fq_valid),
    .q_ready     (fq_ready),
    .q_data      (fq_data)
  );

  tpp_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  tpp_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (qb_valid),
    .q_ready        (qb_ready),
    .q_data         (qb_data),
    .o_valid        (m_tvalid),
    .o_ready        (m_tready),
    .predicted_x    (predicted_x),
    .predicted_y    (predicted_y),
    .positions_held (positions_held)
  );

  assign m_tdata = {1'b0, positions_held, predicted_y, predicted_x};

endmodule

// ----- rtl/core/tpp_checker.sv -----
// Port-level checks for track_position_predictor, bound to the top level.
// Depends on tpp_pkg.
module tpp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [tpp_pkg::S_TDATA_W-1:0]  s_tdata,
  input logic                           s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [tpp_pkg::M_TDATA_W-1:0]  m_tdata
);
  import tpp_pkg::*;

  logic [HELD_W-1:0] held;
  logic              s_busy;

  assign held   = m_tdata[30:28];
  assign s_busy = s_tvalid & s_tready & s_tuser & (s_tdata != '0);

  // a reset edge leaves nothing on the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word present right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output word changed while stalled");

  // count on the output is one to five and the pad bit stays clear
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (held != 3'd0) && (held <= HELD_MAX) && !m_tdata[31])
    else $error("positions_held out of range or pad bit set");

  // a start word taken just out of reset is not yet on the output
  a_no_bypass: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && s_busy |-> !m_tvalid)
    else $error("output word appeared without pipeline latency");

endmodule

bind track_position_predictor tpp_checker u_tpp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/track_position_predictor_test.sv -----
// Self-checking testbench for the track position predictor. Depends on tpp_pkg
// and the RTL. Drives position words on the input stream and checks every word
// out against a local model of the track history or the row's typed values.
`timescale 1ns / 100ps

module track_position_predictor_test;
  import tpp_pkg::*;

  localparam int N_DIR    = 21;
  localparam int N_RANDOM = 2000;
  localparam int COORD_MAX = 4095;

  typedef struct packed {
    logic signed [OUT_W-1:0] px;
    logic signed [OUT_W-1:0] py;
    logic [HELD_W-1:0]       held;
  } guess_t;

  // typed = 1: the expected prediction is given in the row
  typedef struct packed {
    logic                    start;
    logic [IN_COORD_W-1:0]   x;
    logic [IN_COORD_W-1:0]   y;
    logic                    typed;
    logic signed [OUT_W-1:0] wx;
    logic signed [OUT_W-1:0] wy;
    logic [HELD_W-1:0]       wh;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;   // pos_x[11:0], pos_y[23:12]
  logic                  s_tuser;   // start_track
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;   // predicted_x[13:0], predicted_y[27:14],
                                    // positions_held[30:28], zero[31]

  track_position_predictor u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  dir_row_t dir_rows [N_DIR] = '{
    // first word after reset starts a track even without the flag
    '{1'b0, 12'd0,    12'd0,    1'b1, 14'sd0,     14'sd0,     3'd1},
    '{1'b1, 12'd4095, 12'd4095, 1'b1, 14'sd4095,  14'sd4095,  3'd1},
    '{1'b0, 12'd0,    12'd0,    1'b1, -14'sd4095, -14'sd4095, 3'd2},
    '{1'b0, 12'd4095, 12'd0,    1'b0, 14'sd0,     14'sd0,     3'd0},
    '{1'b0, 12'd0,    12'd4095, 1'b0, 14'sd0,     14'sd0,     3'd0},
    '{1'b0, 12'd4095, 12'd4095, 1'b0, 14'sd0,     14'sd0,     3'd0},
    // count saturates, oldest positions drop off
    '{1'b0, 12'd0,    12'd0,    1'b0, 14'sd0,     14'sd0,     3'd0},
    '{1'b0, 12'd4095, 12'd4095, 1'b0, 14'sd0,     14'sd0,     3'd0},
    // four positions with the weighted sum exactly on a half
    '{1'b1, 12'd10,   12'd10,   1'b1, 14'sd10,    14'sd10,    3'd1},
    '{1'b0, 12'd11,   12'd9,    1'b0, 14'sd0,     14'sd0,     3'd0},
    '{1'b0, 12'd12,   12'd8,    1'b0, 14'sd0,     14'sd0,     3'd0},
    '{1'b0, 12'd12,   12'd8,    1'b0, 14'sd0,     14'sd0,     3'd0},
    // five positions, half rounds away from zero on both signs
    '{1'b1, 12'd100,  12'd100,  1'b1, 14'sd100,   14'sd100,   3'd1},
    '{1'b0, 12'd101,  12'd99,   1'b0, 14'sd0,     14'sd0,     3'd0},
    '{1'b0, 12'd101,  12'd99,   1'b0, 14'sd0,     14'sd0,     3'd0},
    '{1'b0, 12'd101,  12'd99,   1'b0, 14'sd0,     14'sd0,     3'd0},
    '{1'b0, 12'd102,  12'd98,   1'b0, 14'sd0,     14'sd0,     3'd0},
    '{1'b1, 12'd2048, 12'd1365, 1'b1, 14'sd2048,  14'sd1365,  3'd1},
    '{1'b0, 12'd1365, 12'd2730, 1'b0, 14'sd0,     14'sd0,     3'd0},
    '{1'b1, 12'd4095, 12'd0,    1'b1, 14'sd4095,  14'sd0,     3'd1},
    '{1'b0, 12'd0,    12'd4095, 1'b1, -14'sd4095, 14'sd8190,  3'd2}
  };

  // track history, entry 0 newest
  int trk_x [HIST_DEPTH];
  int trk_y [HIST_DEPTH];
  int trk_len;

  guess_t guess_q [$];

  int words_in;
  int words_out;
  int tracks_started;
  int full_words;
  int mismatches;
  int strays;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void add_guess(input guess_t g);
    guess_q.insert(guess_q.size(), g);
  endfunction

  function automatic int axis_guess(input bit y_axis);
    int h [HIST_DEPTH];
    int i;
    int steps;
    int sum;
    int mag;
    int q;
    int r;
    for (i = 0; i < HIST_DEPTH; i++) h[i] = y_axis ? trk_y[i] : trk_x[i];
    steps = trk_len - 1;
    if (steps <= 0) return h[0];
    sum = 0;
    for (i = 0; i < steps; i++) sum += (h[i] - h[i+1]) * (steps - i);
    // divide by steps*(steps+1)/2, half away from zero
    mag = (sum < 0) ? -sum : sum;
    q = (mag * 2 + steps * (steps + 1) / 2) / (steps * (steps + 1));
    r = h[0] + ((sum < 0) ? -q : q);
    if (r < OUT_MIN) r = OUT_MIN;
    if (r > OUT_MAX) r = OUT_MAX;
    return r;
  endfunction

  function automatic guess_t advance_track(input logic st,
                                           input logic [IN_COORD_W-1:0] x,
                                           input logic [IN_COORD_W-1:0] y);
    guess_t g;
    int i;
    if (st) trk_len = 0;
    for (i = HIST_DEPTH - 1; i > 0; i--) begin
      trk_x[i] = trk_x[i-1];
      trk_y[i] = trk_y[i-1];
    end
    trk_x[0] = int'(x);
    trk_y[0] = int'(y);
    if (trk_len < HIST_DEPTH) trk_len++;
    g.px   = OUT_W'(axis_guess(1'b0));
    g.py   = OUT_W'(axis_guess(1'b1));
    g.held = HELD_W'(trk_len);
    return g;
  endfunction

  // Called right after the clock rises; returns once the word is accepted.
  task automatic send_word(input logic st, input logic [IN_COORD_W-1:0] x,
                           input logic [IN_COORD_W-1:0] y, output guess_t g);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= st;
    s_tdata  <= {y, x};
    do @(posedge clk); while (!s_tready);
    g = advance_track(st, x, y);
    words_in++;
    if (st || trk_len == 1) tracks_started++;
  endtask

  // receiver: windows of always ready, a sparse pattern, or coin flips,
  // plus two long hold-offs while the sender keeps offering words
  initial begin
    int cyc;
    int mode;
    int hold;
    int holds_done;
    m_tready <= 1'b0;
    cyc = 0;
    mode = 0;
    hold = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 32 == 0) mode = $urandom_range(0, 2);
      if (hold == 0 && ((holds_done == 0 && words_in >= 400) ||
                        (holds_done == 1 && words_in >= 1400))) begin
        hold = 150;
        holds_done++;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= (cyc % 4 == 0);
          default: m_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  always @(posedge clk) begin
    guess_t want;
    guess_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.px   = m_tdata[OUT_W-1:0];
      got.py   = m_tdata[2*OUT_W-1:OUT_W];
      got.held = m_tdata[2*OUT_W+HELD_W-1:2*OUT_W];
      words_out++;
      if (got.held == HELD_MAX) full_words++;
      if (guess_q.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10)
          $display("%0t: output word with no prediction pending: x=%0d y=%0d held=%0d",
                   $realtime, got.px, got.py, got.held);
      end else begin
        want = guess_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches + strays <= 10)
            $display("%0t: word %0d expected x=%0d y=%0d held=%0d, got x=%0d y=%0d held=%0d",
                     $realtime, words_out, want.px, want.py, want.held,
                     got.px, got.py, got.held);
        end
      end
    end
  end

  initial begin
    guess_t g;
    dir_row_t row;
    int n;
    int cur_x;
    int cur_y;
    int vx;
    int vy;
    int kind;
    logic st;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= 1'b0;
    s_tdata <= '0;
    trk_len = 0;
    for (n = 0; n < HIST_DEPTH; n++) begin
      trk_x[n] = 0;
      trk_y[n] = 0;
    end
    words_in = 0;
    words_out = 0;
    tracks_started = 0;
    full_words = 0;
    mismatches = 0;
    strays = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < N_DIR; n++) begin
      row = dir_rows[n];
      send_word(row.start, row.x, row.y, g);
      if (row.typed) begin
        g.px = row.wx;
        g.py = row.wy;
        g.held = row.wh;
      end
      add_guess(g);
    end

    cur_x = 2048;
    cur_y = 2048;
    vx = 0;
    vy = 0;
    for (n = 0; n < N_RANDOM; n++) begin
      st = ($urandom_range(0, 19) == 0);
      if (st) begin
        cur_x = $urandom_range(0, COORD_MAX);
        cur_y = $urandom_range(0, COORD_MAX);
        vx = $urandom_range(0, 80) - 40;
        vy = $urandom_range(0, 80) - 40;
      end else begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          // smooth motion with jitter, clamped to the image
          cur_x += vx + $urandom_range(0, 6) - 3;
          cur_y += vy + $urandom_range(0, 6) - 3;
          if (cur_x < 0) cur_x = 0;
          if (cur_x > COORD_MAX) cur_x = COORD_MAX;
          if (cur_y < 0) cur_y = 0;
          if (cur_y > COORD_MAX) cur_y = COORD_MAX;
        end else if (kind < 9) begin
          cur_x = $urandom_range(0, COORD_MAX);
          cur_y = $urandom_range(0, COORD_MAX);
        end else begin
          cur_x = $urandom_range(0, 1) ? COORD_MAX : 0;
          cur_y = $urandom_range(0, 1) ? COORD_MAX : 0;
        end
      end
      send_word(st, cur_x[IN_COORD_W-1:0], cur_y[IN_COORD_W-1:0], g);
      add_guess(g);
    end
    s_tvalid <= 1'b0;

    while (guess_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d position words in, %0d predictions out, %0d tracks, %0d at full history",
             words_in, words_out, tracks_started, full_words);
    $display("%0d mismatches, %0d unexpected words", mismatches, strays);
    if (mismatches == 0 && strays == 0 && guess_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
